// ===== rtl/core/sndtu_pkg.sv =====
// ----------------------------------------------------------------------------
// sndtu_pkg
// Shared types and constants for the scatter-nd tensor update block.
// ----------------------------------------------------------------------------
package sndtu_pkg;

    localparam int NUM_DIMS      = 4;
    localparam int RANK_BITS     = 3;
    localparam int DIM_BITS      = 13;
    localparam int IDX_BITS      = 12;
    localparam int ADDR_BITS     = 12;
    localparam int VALUE_BITS    = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;

    // A slice covers at most three dimensions of 4096: 2^36 elements.
    localparam int CNT_BITS      = 37;
    // The whole tensor covers at most four dimensions: 2^48 elements.
    localparam int TOTAL_BITS    = 49;

    localparam logic [DIM_BITS-1:0] DIM_MAX = 13'd4096;

    // Configuration register indices
    localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_RANK   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_DEPTH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM0_SIZE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM1_SIZE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM2_SIZE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM3_SIZE   = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INDEX    = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_ADDRESS  = 2'd3
    } status_t;

endpackage

// ===== rtl/core/scatter_nd_tensor_update_top.sv =====
// ----------------------------------------------------------------------------
// scatter_nd_tensor_update_top
// Tensor store with element load/read and scatter-nd slice updates.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//  in        in_valid  / in_stall   op, addr, value, idx0..idx3
//  out       out_valid / out_stall  read_value, status, slice_full
//
//  One item per cycle when nothing stalls; each item gives one result
//  transfer, by way of the input register, product register and result register.
//  After reset the block is ready at once with the reset register values.
//  A configuration write starts the stride unit, one 37x13 multiplier that
//  walks the four dimensions: in_stall and !cfg_ready hold until it is done.
//  out_stall freezes the result register and backs up into in_stall.
//
module scatter_nd_tensor_update_top #(
    parameter int MAX_RANK    = 4,
    parameter int STORE_DEPTH = 4096,
    parameter int ELEM_BITS   = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sndtu_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [sndtu_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             op,
    input  logic [sndtu_pkg::ADDR_BITS-1:0]        addr,
    input  logic signed [sndtu_pkg::VALUE_BITS-1:0] value,
    input  logic [sndtu_pkg::IDX_BITS-1:0]         idx0,
    input  logic [sndtu_pkg::IDX_BITS-1:0]         idx1,
    input  logic [sndtu_pkg::IDX_BITS-1:0]         idx2,
    input  logic [sndtu_pkg::IDX_BITS-1:0]         idx3,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sndtu_pkg::VALUE_BITS-1:0] read_value,
    output logic [1:0]                             status,
    output logic                                   slice_full
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    // Saturating width for slice base arithmetic: all-ones is >= STORE_DEPTH
    localparam int SW       = AW + 1;
    localparam int TW       = sndtu_pkg::IDX_BITS + SW;
    localparam int SUMW     = TW + 2;
    localparam int AXW      = sndtu_pkg::CNT_BITS + 1;
    localparam int MULW     = sndtu_pkg::CNT_BITS + sndtu_pkg::DIM_BITS;
    localparam int RANK_CAP = (MAX_RANK < sndtu_pkg::NUM_DIMS) ? MAX_RANK
                                                               : sndtu_pkg::NUM_DIMS;
    localparam int ND       = sndtu_pkg::NUM_DIMS;

    localparam logic [SW-1:0] SATV = {SW{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [sndtu_pkg::RANK_BITS-1:0] data_rank_reg;
    logic [sndtu_pkg::RANK_BITS-1:0] index_depth_reg;
    logic [sndtu_pkg::DIM_BITS-1:0]  dim_size_reg [ND];

    logic cfg_fire;

    assign cfg_fire = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_rank_reg   <= 3'd4;
            index_depth_reg <= 3'd1;
            for (int k = 0; k < ND; k++)
            begin
                dim_size_reg[k] <= 13'd1;
            end
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                sndtu_pkg::CFG_DATA_RANK:   data_rank_reg   <= cfg_data[2:0];
                sndtu_pkg::CFG_INDEX_DEPTH: index_depth_reg <= cfg_data[2:0];
                sndtu_pkg::CFG_DIM0_SIZE:   dim_size_reg[0] <= cfg_data;
                sndtu_pkg::CFG_DIM1_SIZE:   dim_size_reg[1] <= cfg_data;
                sndtu_pkg::CFG_DIM2_SIZE:   dim_size_reg[2] <= cfg_data;
                sndtu_pkg::CFG_DIM3_SIZE:   dim_size_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Clamped register values
    logic [sndtu_pkg::RANK_BITS-1:0] rank_eff;
    logic [sndtu_pkg::RANK_BITS-1:0] depth_eff;
    logic [sndtu_pkg::DIM_BITS-1:0]  dim_eff [ND];

    always_comb
    begin
        if (data_rank_reg == 3'd0)
            rank_eff = 3'd1;
        else if (data_rank_reg > 3'(RANK_CAP))
            rank_eff = 3'(RANK_CAP);
        else
            rank_eff = data_rank_reg;

        if (index_depth_reg == 3'd0)
            depth_eff = 3'd1;
        else if (index_depth_reg > rank_eff)
            depth_eff = rank_eff;
        else
            depth_eff = index_depth_reg;

        for (int k = 0; k < ND; k++)
        begin
            if (dim_size_reg[k] == '0)
                dim_eff[k] = 13'd1;
            else if (dim_size_reg[k] > sndtu_pkg::DIM_MAX)
                dim_eff[k] = sndtu_pkg::DIM_MAX;
            else
                dim_eff[k] = dim_size_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Stride unit: suffix products of the dimension sizes, innermost first.
    // suffix_reg[k] = product of dims k..rank-1 (k = 1..3), total_reg the
    // product over all dims, stride_sat_reg[k] = suffix of k+1, saturated.
    // ------------------------------------------------------------------
    logic                            busy_reg;
    logic [1:0]                      step_reg;
    logic [sndtu_pkg::CNT_BITS-1:0]  prod_reg;
    logic [sndtu_pkg::CNT_BITS-1:0]  suffix_reg [ND-1:1];
    logic [sndtu_pkg::TOTAL_BITS-1:0] total_reg;
    logic [SW-1:0]                   stride_sat_reg [ND-1];

    logic [sndtu_pkg::DIM_BITS-1:0]  seq_dim;
    logic [MULW-1:0]                 seq_mult;
    logic [SW-1:0]                   seq_sat;

    always_comb
    begin
        seq_dim  = ({1'b0, step_reg} < rank_eff) ? dim_eff[step_reg] : 13'd1;
        seq_mult = MULW'(prod_reg) * MULW'(seq_dim);
        seq_sat  = (seq_mult > MULW'(SATV)) ? SATV : seq_mult[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= 2'd3;
            prod_reg  <= 37'd1;
            total_reg <= 49'd1;
            for (int k = 1; k < ND; k++)
            begin
                suffix_reg[k] <= 37'd1;
            end
            for (int k = 0; k < ND - 1; k++)
            begin
                stride_sat_reg[k] <= SW'(1);
            end
        end
        else if (cfg_fire)
        begin
            busy_reg <= 1'b1;
            step_reg <= 2'd3;
            prod_reg <= 37'd1;
        end
        else if (busy_reg)
        begin
            prod_reg <= seq_mult[sndtu_pkg::CNT_BITS-1:0];
            if (step_reg == 2'd0)
            begin
                total_reg <= seq_mult[sndtu_pkg::TOTAL_BITS-1:0];
                busy_reg  <= 1'b0;
            end
            else
            begin
                suffix_reg[step_reg]              <= seq_mult[sndtu_pkg::CNT_BITS-1:0];
                stride_sat_reg[2'(step_reg - 2'd1)] <= seq_sat;
                step_reg                          <= step_reg - 2'd1;
            end
        end
    end

    assign cfg_ready = !busy_reg;

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s2_adv;
    logic s2_fire;
    logic a_move;
    logic in_fire;

    assign s2_adv   = !out_valid_reg || !out_stall;
    assign s2_fire  = s2_valid_reg && s2_adv;
    assign a_move   = !s2_valid_reg || s2_adv;
    assign in_stall = busy_reg || (s1_valid_reg && !a_move);
    assign in_fire  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    sndtu_pkg::op_t                  s1_op_reg;
    logic [sndtu_pkg::ADDR_BITS-1:0] s1_addr_reg;
    logic [sndtu_pkg::VALUE_BITS-1:0] s1_value_reg;
    logic [sndtu_pkg::IDX_BITS-1:0]  s1_idx_reg [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (a_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= sndtu_pkg::op_t'(op);
            s1_addr_reg   <= addr;
            s1_value_reg  <= value;
            s1_idx_reg[0] <= idx0;
            s1_idx_reg[1] <= idx1;
            s1_idx_reg[2] <= idx2;
            s1_idx_reg[3] <= idx3;
        end
    end

    // ------------------------------------------------------------------
    // Index check and stride products (no dependence on slice state)
    // ------------------------------------------------------------------
    logic [SW-1:0] stride_w [ND];
    logic [TW-1:0] term     [ND];
    logic          idx_bad;

    always_comb
    begin
        idx_bad = 1'b0;
        for (int k = 0; k < ND; k++)
        begin
            stride_w[k] = (k < ND - 1) ? stride_sat_reg[(k < ND - 1) ? k : 0] : SW'(1);
            if (3'(k) < depth_eff)
            begin
                if ({1'b0, s1_idx_reg[k]} >= dim_eff[k])
                    idx_bad = 1'b1;
                term[k] = TW'(s1_idx_reg[k]) * TW'(stride_w[k]);
            end
            else
            begin
                term[k] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Product register
    // ------------------------------------------------------------------
    sndtu_pkg::op_t                  s2_op_reg;
    logic [sndtu_pkg::ADDR_BITS-1:0] s2_addr_reg;
    logic [sndtu_pkg::VALUE_BITS-1:0] s2_value_reg;
    logic                            s2_bad_reg;
    logic [TW-1:0]                   s2_term_reg [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (a_move)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_move && s1_valid_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_value_reg <= s1_value_reg;
            s2_bad_reg   <= idx_bad;
            for (int k = 0; k < ND; k++)
            begin
                s2_term_reg[k] <= term[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Slice state, store access and result
    // ------------------------------------------------------------------
    logic [SW-1:0]                  slice_base_reg;
    logic [sndtu_pkg::CNT_BITS-1:0] slice_count_reg;
    logic                           slice_open_reg;

    logic [SW-1:0]                  slice_base_next;
    logic [sndtu_pkg::CNT_BITS-1:0] slice_count_next;
    logic                           slice_open_next;

    logic [SUMW-1:0]                base_sum;
    logic [SW-1:0]                  base_sat;
    logic [sndtu_pkg::CNT_BITS-1:0] slice_size;
    logic [sndtu_pkg::CNT_BITS-1:0] count_inc;
    logic [AXW-1:0]                 upd_addr;
    logic                           addr_ok;

    sndtu_pkg::status_t             res_status;
    logic                           res_full;
    logic                           res_rd_sel;
    logic                           mem_we;
    logic                           mem_re;
    logic [AW-1:0]                  mem_addr;
    logic [ELEM_BITS-1:0]           mem_wdata;

    always_comb
    begin
        base_sum = SUMW'(s2_term_reg[0]) + SUMW'(s2_term_reg[1])
                 + SUMW'(s2_term_reg[2]) + SUMW'(s2_term_reg[3]);
        base_sat = (base_sum > SUMW'(SATV)) ? SATV : base_sum[SW-1:0];

        case (depth_eff)
            3'd1:    slice_size = suffix_reg[1];
            3'd2:    slice_size = suffix_reg[2];
            3'd3:    slice_size = suffix_reg[3];
            default: slice_size = 37'd1;
        endcase

        count_inc = slice_count_reg + 37'd1;
        upd_addr  = AXW'(slice_base_reg) + AXW'(slice_count_reg);
        addr_ok   = (sndtu_pkg::TOTAL_BITS'(s2_addr_reg) < total_reg)
                 && (AXW'(s2_addr_reg) < AXW'(STORE_DEPTH));

        slice_base_next  = slice_base_reg;
        slice_count_next = slice_count_reg;
        slice_open_next  = slice_open_reg;
        res_status       = sndtu_pkg::ST_OK;
        res_full         = 1'b0;
        res_rd_sel       = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = AW'(s2_addr_reg);
        mem_wdata        = ELEM_BITS'(s2_value_reg);

        case (s2_op_reg)
            sndtu_pkg::OP_LOAD:
            begin
                if (!addr_ok)
                    res_status = sndtu_pkg::ST_ADDRESS;
                else
                    mem_we = s2_fire;
            end
            sndtu_pkg::OP_READ:
            begin
                if (!addr_ok)
                    res_status = sndtu_pkg::ST_ADDRESS;
                else
                begin
                    mem_re     = s2_fire;
                    res_rd_sel = 1'b1;
                end
            end
            sndtu_pkg::OP_START:
            begin
                slice_count_next = '0;
                if (s2_bad_reg)
                begin
                    res_status      = sndtu_pkg::ST_INDEX;
                    slice_open_next = 1'b0;
                end
                else
                begin
                    slice_base_next = base_sat;
                    slice_open_next = 1'b1;
                end
            end
            sndtu_pkg::OP_UPDATE:
            begin
                if (!slice_open_reg || (slice_count_reg >= slice_size))
                    res_status = sndtu_pkg::ST_OVERRUN;
                else
                begin
                    mem_addr = upd_addr[AW-1:0];
                    // Past the store: dropped, but the position is used up
                    if (upd_addr >= AXW'(STORE_DEPTH))
                        res_status = sndtu_pkg::ST_ADDRESS;
                    else
                        mem_we = s2_fire;
                    slice_count_next = count_inc;
                    if (count_inc >= slice_size)
                    begin
                        res_full        = 1'b1;
                        slice_open_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_base_reg  <= '0;
            slice_count_reg <= '0;
            slice_open_reg  <= 1'b0;
        end
        else if (s2_fire)
        begin
            slice_base_reg  <= slice_base_next;
            slice_count_reg <= slice_count_next;
            slice_open_reg  <= slice_open_next;
        end
    end

    // Tensor store: one port, registered read data doubles as result data
    logic [ELEM_BITS-1:0] store_mem [STORE_DEPTH];
    logic [ELEM_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= store_mem[mem_addr];
    end

    // Result register
    logic [1:0] status_reg;
    logic       full_reg;
    logic       rd_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= sndtu_pkg::ST_OK;
            full_reg   <= 1'b0;
            rd_sel_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            status_reg <= res_status;
            full_reg   <= res_full;
            rd_sel_reg <= res_rd_sel;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slice_full = full_reg;
    assign read_value = rd_sel_reg ? sndtu_pkg::VALUE_BITS'(rdata_reg) : '0;

endmodule

// ===== rtl/core/sndtu_checker.sv =====
// ----------------------------------------------------------------------------
// sndtu_checker
// Port-level checks for the scatter-nd tensor update block.
// ----------------------------------------------------------------------------
module sndtu_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    cfg_valid,
    input logic                                    cfg_ready,
    input logic                                    in_stall,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [sndtu_pkg::VALUE_BITS-1:0] read_value,
    input logic [1:0]                              status,
    input logic                                    slice_full
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
                                   && $stable(read_value) && $stable(slice_full))
        else $error("result changed while stalled");

    // Closing a slice only happens on an update that used a slice position;
    // a position past the store still counts
    a_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slice_full |-> (status == sndtu_pkg::ST_OK)
                                    || (status == sndtu_pkg::ST_ADDRESS))
        else $error("slice_full with error status");

    // Read data only accompanies a good transfer
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_value != '0) |-> status == sndtu_pkg::ST_OK)
        else $error("read data with error status");

    // Stride recompute blocks items and further writes
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
        else $error("input open during stride recompute");

endmodule

bind scatter_nd_tensor_update_top sndtu_checker u_sndtu_checker (.*);

// ===== verif/scatter_nd_tensor_update_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scatter_nd_tensor_update testbench
// Self-checking bench for the scatter-nd tensor store. A short table of
// directed transfers runs first, then a series of register settings, each
// followed by random slices, loads and reads. Every accepted transfer is run
// through an in-bench shadow of the store and slice logic, and the block's
// results are checked in order against it or the table's written expectation.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int STORE_WORDS  = 4096;
    localparam int DIM_CAP      = 4096;
    localparam int HOLD_CYCLES  = 120;   // long receiver hold-off for back-pressure
    localparam int WD_LIMIT     = 1000;  // cycles with no transfer before giving up
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 52;
    localparam int MAX_PRINTS   = 200;

    localparam int ADDR_W = sndtu_pkg::ADDR_BITS;
    localparam int IDX_W  = sndtu_pkg::IDX_BITS;
    localparam int VAL_W  = sndtu_pkg::VALUE_BITS;
    localparam int CFG_W  = sndtu_pkg::CFG_DATA_BITS;
    localparam int CIX_W  = sndtu_pkg::CFG_IDX_BITS;
    localparam int NDIM   = sndtu_pkg::NUM_DIMS;

    typedef struct packed {
        sndtu_pkg::op_t                op;
        logic [ADDR_W-1:0]             addr;
        logic signed [VAL_W-1:0]       value;
        logic [NDIM-1:0][IDX_W-1:0]    idx;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]       rv;
        sndtu_pkg::status_t            st;
        logic                          full;
    } result_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        item_t                     item;
        bit                        typed;   // expectation written into the table
        result_t                   want;
        logic [CIX_W-1:0]          cfg_idx;
        logic [CFG_W-1:0]          cfg_val;
    } row_t;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CIX_W-1:0]              cfg_index;
    logic [CFG_W-1:0]              cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    op;
    logic [ADDR_W-1:0]             addr;
    logic signed [VAL_W-1:0]       value;
    logic [IDX_W-1:0]              idx0, idx1, idx2, idx3;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [VAL_W-1:0]       read_value;
    logic [1:0]                    status;
    logic                          slice_full;

    scatter_nd_tensor_update_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .addr       (addr),
        .value      (value),
        .idx0       (idx0),
        .idx1       (idx1),
        .idx2       (idx2),
        .idx3       (idx3),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .slice_full (slice_full)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register copies, store and slice tracking.
    // The shadow is advanced at the edge where each transfer is accepted,
    // so it always reflects the order the block sees.
    // ------------------------------------------------------------------
    logic [2:0]                rank_reg  = 3'd4;
    logic [2:0]                depth_reg = 3'd1;
    logic [CFG_W-1:0]          dim_reg [NDIM] = '{default: 13'd1};

    logic [VAL_W-1:0]          shadow_mem [STORE_WORDS];
    bit                        written [STORE_WORDS];   // entries safe to read back
    int                        written_q [$];
    longint unsigned           sl_base  = 0;
    longint unsigned           sl_count = 0;
    bit                        sl_open  = 1'b0;

    result_t                   awaited_q [$];   // results still owed by the block
    result_t                   head;
    row_t                      dir_tab [$];     // directed stimulus table
    int                        faults    = 0;
    int                        res_seen  = 0;
    int                        sent      = 0;
    bit                        quiet     = 1'b0; // no idling on either side
    bit                        hold_req  = 1'b0;

    // Register values as the block interprets them: out-of-range settings
    // saturate rather than wrap.
    function automatic int unsigned act_rank();
        if (rank_reg < 1)
            return 1;
        if (rank_reg > NDIM)
            return NDIM;
        return rank_reg;
    endfunction

    function automatic int unsigned act_depth(int unsigned rk);
        if (depth_reg < 1)
            return 1;
        if (depth_reg > rk)
            return rk;
        return depth_reg;
    endfunction

    function automatic longint unsigned act_dim(int k);
        if (dim_reg[k] == 0)
            return 1;
        if (dim_reg[k] > DIM_CAP)
            return DIM_CAP;
        return dim_reg[k];
    endfunction

    // Product of dimension sizes over [lo, hi)
    function automatic longint unsigned dim_span(int lo, int hi);
        longint unsigned p;
        p = 1;
        for (int k = lo; k < hi; k++)
            p = p * act_dim(k);
        return p;
    endfunction

    function automatic void store_word(longint unsigned a, logic [VAL_W-1:0] v);
        shadow_mem[a] = v;
        if (!written[a])
        begin
            written[a] = 1'b1;
            written_q.insert(written_q.size(), int'(a));
        end
    endfunction

    function automatic void reg_write(logic [CIX_W-1:0] ri, logic [CFG_W-1:0] d);
        case (ri)
            sndtu_pkg::CFG_DATA_RANK:   rank_reg   = d[2:0];
            sndtu_pkg::CFG_INDEX_DEPTH: depth_reg  = d[2:0];
            sndtu_pkg::CFG_DIM0_SIZE:   dim_reg[0] = d;
            sndtu_pkg::CFG_DIM1_SIZE:   dim_reg[1] = d;
            sndtu_pkg::CFG_DIM2_SIZE:   dim_reg[2] = d;
            sndtu_pkg::CFG_DIM3_SIZE:   dim_reg[3] = d;
            default: ;
        endcase
    endfunction

    // Expected result of one transfer; updates store and slice state.
    function automatic result_t tensor_step(item_t it);
        result_t          r;
        int unsigned      rk;
        int unsigned      dp;
        longint unsigned  tot;
        longint unsigned  base;
        longint unsigned  size;
        longint unsigned  a;
        bit               bad;
        r.rv   = '0;
        r.st   = sndtu_pkg::ST_OK;
        r.full = 1'b0;
        rk  = act_rank();
        dp  = act_depth(rk);
        tot = dim_span(0, rk);
        case (it.op)
            sndtu_pkg::OP_LOAD, sndtu_pkg::OP_READ:
            begin
                if (it.addr >= tot || it.addr >= STORE_WORDS)
                    r.st = sndtu_pkg::ST_ADDRESS;
                else if (it.op == sndtu_pkg::OP_LOAD)
                    store_word(it.addr, it.value);
                else
                    r.rv = shadow_mem[it.addr];
            end
            sndtu_pkg::OP_START:
            begin
                base = 0;
                bad  = 1'b0;
                for (int k = 0; k < dp; k++)
                begin
                    if (it.idx[k] >= act_dim(k))
                        bad = 1'b1;
                    base = base * act_dim(k) + it.idx[k];
                end
                sl_count = 0;
                if (bad)
                begin
                    r.st    = sndtu_pkg::ST_INDEX;
                    sl_open = 1'b0;
                end
                else
                begin
                    sl_base = base * dim_span(dp, rk);
                    sl_open = 1'b1;
                end
            end
            default:
            begin
                // slice size follows the registers at the time of each update
                size = dim_span(dp, rk);
                if (!sl_open || sl_count >= size)
                    r.st = sndtu_pkg::ST_OVERRUN;
                else
                begin
                    a = sl_base + sl_count;
                    if (a >= STORE_WORDS)
                        r.st = sndtu_pkg::ST_ADDRESS;   // dropped, position used up
                    else
                        store_word(a, it.value);
                    sl_count++;
                    if (sl_count >= size)
                    begin
                        r.full  = 1'b1;
                        sl_open = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.op    = sndtu_pkg::op_t'($urandom_range(0, 3));
        it.addr  = ADDR_W'($urandom);
        it.value = $urandom;
        for (int k = 0; k < NDIM; k++)
            it.idx[k] = IDX_W'($urandom);
        return it;
    endfunction

    function automatic row_t item_row(sndtu_pkg::op_t o, logic [ADDR_W-1:0] a,
                                      logic [VAL_W-1:0] v, logic [IDX_W-1:0] i0,
                                      bit chk = 1'b0, logic [VAL_W-1:0] rv = '0,
                                      sndtu_pkg::status_t st = sndtu_pkg::ST_OK,
                                      bit full = 1'b0);
        row_t r;
        r.kind        = ROW_ITEM;
        r.item.op     = o;
        r.item.addr   = a;
        r.item.value  = v;
        r.item.idx    = {NDIM{12'hFFF}};   // unused indices sit at their maximum
        r.item.idx[0] = i0;
        r.typed       = chk;
        r.want.rv     = rv;
        r.want.st     = st;
        r.want.full   = full;
        r.cfg_idx     = sndtu_pkg::CFG_DATA_RANK;
        r.cfg_val     = '0;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CIX_W-1:0] ri, logic [CFG_W-1:0] d);
        row_t r;
        r       = item_row(sndtu_pkg::OP_LOAD, 0, 0, 0);
        r.kind  = ROW_CFG;
        r.cfg_idx = ri;
        r.cfg_val = d;
        return r;
    endfunction

    function automatic void add_row(row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    task automatic report(input string msg);
        faults++;
        if (faults <= MAX_PRINTS)
            $display("%0t: result %0d: %s", $time, res_seen, msg);
    endtask

    // Offer one transfer and hold it until accepted. Reads that would touch
    // a never-written entry are turned into loads of that entry instead.
    task automatic send(input item_t it, input bit typed = 1'b0, input result_t want = '0);
        result_t calc;
        if (it.op == sndtu_pkg::OP_READ && it.addr < dim_span(0, act_rank())
            && !written[it.addr])
            it.op = sndtu_pkg::OP_LOAD;
        in_valid <= 1'b1;
        op       <= it.op;
        addr     <= it.addr;
        value    <= it.value;
        idx0     <= it.idx[0];
        idx1     <= it.idx[1];
        idx2     <= it.idx[2];
        idx3     <= it.idx[3];
        do
            @(posedge clk);
        while (in_stall);
        calc = tensor_step(it);
        awaited_q.insert(awaited_q.size(), typed ? want : calc);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_q.size() != 0);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic cfg_write(input logic [CIX_W-1:0] ri, input logic [CFG_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_write(ri, d);
    endtask

    task automatic apply_shape(input logic [CFG_W-1:0] rk, dp, d0, d1, d2, d3);
        drain();
        cfg_write(sndtu_pkg::CFG_DATA_RANK, rk);
        cfg_write(sndtu_pkg::CFG_INDEX_DEPTH, dp);
        cfg_write(sndtu_pkg::CFG_DIM0_SIZE, d0);
        cfg_write(sndtu_pkg::CFG_DIM1_SIZE, d1);
        cfg_write(sndtu_pkg::CFG_DIM2_SIZE, d2);
        cfg_write(sndtu_pkg::CFG_DIM3_SIZE, d3);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small sizes, now and then an extreme or out-of-range one
    function automatic logic [CFG_W-1:0] rand_dim();
        case ($urandom_range(0, 15))
            0:       return 13'd0;
            1:       return sndtu_pkg::DIM_MAX;
            2:       return 13'h1FFF;
            3:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // One burst of random traffic under the current setting.
    task automatic burst();
        item_t            it;
        item_t            aside;
        int unsigned      rk;
        int unsigned      dp;
        int unsigned      j;
        longint unsigned  size;
        longint unsigned  lim;
        int               n;
        int               pick;
        rk   = act_rank();
        dp   = act_depth(rk);
        lim  = dim_span(0, rk);
        if (lim > STORE_WORDS)
            lim = STORE_WORDS;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
        begin
            // mostly well-formed slice: a tuple, now and then out of range, then updates up to the slice size
            it    = noise_item();
            it.op = sndtu_pkg::OP_START;
            for (int k = 0; k < dp; k++)
                it.idx[k] = IDX_W'($urandom_range(0, int'(act_dim(k)) - 1));
            if ($urandom_range(0, 7) == 0)
            begin
                j = $urandom_range(0, dp - 1);
                if (act_dim(j) < DIM_CAP)
                    it.idx[j] = IDX_W'($urandom_range(int'(act_dim(j)), DIM_CAP - 1));
            end
            send(it);
            size = dim_span(dp, rk);
            n = (size <= 12) ? int'(size) : $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 2);       // run past the end of the slice
            repeat (n)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    aside      = noise_item();
                    aside.op   = ($urandom_range(0, 1) == 0) ? sndtu_pkg::OP_LOAD
                                                             : sndtu_pkg::OP_READ;
                    aside.addr = ADDR_W'($urandom_range(0, int'(lim) - 1));
                    send(aside);
                end
                it    = noise_item();
                it.op = sndtu_pkg::OP_UPDATE;
                send(it);
            end
        end
        else if (pick == 6)
        begin
            repeat ($urandom_range(1, 4))
            begin
                it      = noise_item();
                it.op   = sndtu_pkg::OP_LOAD;
                it.addr = ADDR_W'($urandom_range(0, int'(lim) - 1));
                send(it);
            end
        end
        else if (pick == 7)
        begin
            repeat ($urandom_range(1, 4))
            begin
                it    = noise_item();
                it.op = sndtu_pkg::OP_READ;
                if (written_q.size() != 0)
                    it.addr = ADDR_W'(written_q[$urandom_range(0, written_q.size() - 1)]);
                send(it);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                send(noise_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every result transfer is matched against the oldest
    // owed result, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_q.size() == 0)
                report("result transfer with nothing owed");
            else
            begin
                head = awaited_q.pop_front();
                if (read_value !== head.rv)
                    report($sformatf("read_value %0d, want %0d", read_value, head.rv));
                if (status !== head.st)
                    report($sformatf("status %0d, want %s", status, head.st.name()));
                if (slice_full !== head.full)
                    report($sformatf("slice_full %b, want %b", slice_full, head.full));
            end
            res_seen++;
        end
    end

    // Receiver: random stall runs, plus one long hold-off on request so the
    // block fills and pushes back on its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WD_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[scatter_nd_tensor_update_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] shape_tab [7][6] = '{
        '{13'd3, 13'd1, 13'd4,    13'd3,    13'd2,    13'd8191},  // small slices, rank 3
        '{13'd4, 13'd2, 13'd2,    13'd3,    13'd2,    13'd2},     // two-deep tuples
        '{13'd1, 13'd1, 13'd4096, 13'd5,    13'd5,    13'd5},     // rank 1, single-element slices
        '{13'd4, 13'd4, 13'd8,    13'd8,    13'd8,    13'd8},     // full-depth tuples
        '{13'd0, 13'd0, 13'd0,    13'd0,    13'd0,    13'd0},     // everything saturates low
        '{13'd7, 13'd7, 13'd8191, 13'd8191, 13'd8191, 13'd8191},  // everything saturates high
        '{13'd3, 13'd1, 13'd2,    13'd64,   13'd64,   13'd0}      // 4096-element slices
    };

    initial
    begin
        bit    cfg_open;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sndtu_pkg::CFG_DATA_RANK;
        cfg_data  = '0;
        in_valid  = 1'b0;
        op        = sndtu_pkg::OP_LOAD;
        addr      = '0;
        value     = '0;
        idx0      = '0;
        idx1      = '0;
        idx2      = '0;
        idx3      = '0;
        out_stall = 1'b0;
        cfg_open  = 1'b0;

        // Reset setting: rank 4, depth 1, all sizes 1, so the tensor is a
        // single element and every slice is one element long.
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 5, 0, 1, 0,
                         sndtu_pkg::ST_OVERRUN));   // nothing open yet
        add_row(item_row(sndtu_pkg::OP_READ, 4095, 0, 0, 1, 0, sndtu_pkg::ST_ADDRESS));
        add_row(item_row(sndtu_pkg::OP_LOAD, 4095, 32'h7FFF_FFFF, 0, 1, 0,
                         sndtu_pkg::ST_ADDRESS));
        add_row(item_row(sndtu_pkg::OP_LOAD, 0, 32'h8000_0000, 0, 1, 0, sndtu_pkg::ST_OK));
        add_row(item_row(sndtu_pkg::OP_READ, 0, 0, 0, 1, 32'h8000_0000, sndtu_pkg::ST_OK));
        add_row(item_row(sndtu_pkg::OP_START, 0, 0, 0, 1, 0, sndtu_pkg::ST_OK));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 32'h7FFF_FFFF, 0, 1, 0,
                         sndtu_pkg::ST_OK, 1'b1));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 0, 0, 1, 0,
                         sndtu_pkg::ST_OVERRUN));   // slice closed
        add_row(item_row(sndtu_pkg::OP_READ, 0, 0, 0, 1, 32'h7FFF_FFFF, sndtu_pkg::ST_OK));
        add_row(item_row(sndtu_pkg::OP_START, 0, 0, 1, 1, 0, sndtu_pkg::ST_INDEX));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 0, 0, 1, 0,
                         sndtu_pkg::ST_OVERRUN));   // bad tuple closed it
        add_row(item_row(sndtu_pkg::OP_START, 0, 0, 4095, 1, 0, sndtu_pkg::ST_INDEX));
        add_row(item_row(sndtu_pkg::OP_START, 0, 0, 0));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 32'hFFFF_FFFF, 0));
        add_row(item_row(sndtu_pkg::OP_READ, 0, 0, 0));
        // 4096 x 4 tensor: a slice at the far row lies wholly past the store
        add_row(cfg_row(sndtu_pkg::CFG_DATA_RANK, 2));
        add_row(cfg_row(sndtu_pkg::CFG_DIM0_SIZE, 4096));
        add_row(cfg_row(sndtu_pkg::CFG_DIM1_SIZE, 4));
        add_row(item_row(sndtu_pkg::OP_START, 0, 0, 4095, 1, 0, sndtu_pkg::ST_OK));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 1, 0, 1, 0, sndtu_pkg::ST_ADDRESS));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 2, 0, 1, 0, sndtu_pkg::ST_ADDRESS));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 3, 0, 1, 0, sndtu_pkg::ST_ADDRESS));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 4, 0, 1, 0,
                         sndtu_pkg::ST_ADDRESS, 1'b1));
        add_row(item_row(sndtu_pkg::OP_START, 0, 0, 1));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 32'h1234_5678, 0));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 32'hEDCB_A987, 0));
        // shrink the slice under an open one: count already at the new size
        add_row(cfg_row(sndtu_pkg::CFG_DIM1_SIZE, 2));
        add_row(item_row(sndtu_pkg::OP_UPDATE, 0, 9, 0, 1, 0, sndtu_pkg::ST_OVERRUN));
        add_row(item_row(sndtu_pkg::OP_READ, 5, 0, 0, 1, 32'hEDCB_A987, sndtu_pkg::ST_OK));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; register rows are only written with the block idle
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    drain();
                cfg_write(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // Random phases: a fixed list of settings first, then random ones
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            int start_cnt;
            quiet = (p == 1 || p == 8);
            if (p < 7)
                apply_shape(shape_tab[p][0], shape_tab[p][1], shape_tab[p][2],
                            shape_tab[p][3], shape_tab[p][4], shape_tab[p][5]);
            else
                apply_shape(CFG_W'($urandom), CFG_W'($urandom), rand_dim(), rand_dim(),
                            rand_dim(), rand_dim());
            if (p == 3)
                hold_req = 1'b1;
            start_cnt = sent;
            while (sent - start_cnt < PHASE_ITEMS)
                burst();
        end

        drain();
        repeat (8) @(posedge clk);   // catch any stray result transfer

        if (faults == 0)
            $display("[scatter_nd_tensor_update_top] OK");
        else
            $display("[scatter_nd_tensor_update_top] ERROR");
        $finish;
    end

endmodule
